// File: rtl/core/crgd_pkg.sv
package crgd_pkg;

  // Fixed field widths of the external payload.
  localparam int unsigned SampleW   = 12;
  localparam int unsigned ShortSumW = 16;
  localparam int unsigned ThrW      = 19;

  // Threshold value after reset, in hundredths of an ADC LSB.
  localparam logic [ThrW-1:0] ThrReset = 19'd1861;

  typedef enum logic [1:0] {
    PHASE_OFF  = 2'd0,
    PHASE_WARM = 2'd1,
    PHASE_MON  = 2'd2
  } phase_e;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               gate_open;
  } in_t;

  typedef struct packed {
    logic                 detected;
    phase_e               phase;
    logic [ShortSumW-1:0] short_sum;
  } out_t;

endpackage

// File: rtl/core/current_rise_grip_detector_top.sv
// Current-rise grip detector.
// Throughput: one beat per cycle unless the output stalls and every stage is full.
// Stages: sum update, constant products, and final add and compare, each registered
// with its own valid bit.
// Reset: asynchronous, active low; clears the running sums, counters, baseline and
// pipeline valids and loads the default threshold. The history cells are not reset.
module current_rise_grip_detector_top #(
  parameter int unsigned LONG_WINDOW  = 100,
  parameter int unsigned SHORT_WINDOW = 10,
  parameter int unsigned WARMUP_TICKS = 200,
  parameter int unsigned SAMPLE_BITS  = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [crgd_pkg::ThrW-1:0]        cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  crgd_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output crgd_pkg::out_t                   out_data_o
);

  import crgd_pkg::*;

  // Bounds of the exact sums. The comparison is
  //   100*L*recent > 100*S*baseline + S*L*threshold
  // and neither side exceeds CmpMax.
  localparam longint unsigned SampleMax = (64'd1 << SAMPLE_BITS) - 64'd1;
  localparam longint unsigned ThrMax    = (64'd1 << ThrW) - 64'd1;
  localparam longint unsigned RecentMax = SHORT_WINDOW * SampleMax;
  localparam longint unsigned WindowMax = LONG_WINDOW * SampleMax;
  localparam longint unsigned CmpMax    =
    longint'(SHORT_WINDOW) * LONG_WINDOW * (100 * SampleMax + ThrMax);

  localparam int unsigned RecentW = $clog2(RecentMax + 1);
  localparam int unsigned WindowW = $clog2(WindowMax + 1);
  localparam int unsigned CmpW    = $clog2(CmpMax + 1);
  localparam int unsigned WarmW   = $clog2(WARMUP_TICKS + 2);
  localparam int unsigned FillW   = $clog2(LONG_WINDOW + 1);

  localparam longint unsigned LhsK  = 100 * LONG_WINDOW;
  localparam longint unsigned BaseK = 100 * SHORT_WINDOW;
  localparam longint unsigned ThrK  = SHORT_WINDOW * LONG_WINDOW;

  // ---------------------------------------------------------------------------
  // Handshake and stage advance. Each stage moves when it is empty or when the
  // stage after it moves, so bubbles are squeezed out while the output stalls.
  // ---------------------------------------------------------------------------
  logic out_vld_q, s2_vld_q, s1_vld_q;
  logic out_adv, s2_adv, s1_adv, in_fire;

  assign out_adv    = !out_vld_q || out_ready_i;
  assign s2_adv     = !s2_vld_q || out_adv;
  assign s1_adv     = !s1_vld_q || s2_adv;
  assign in_ready_o = s1_adv;
  assign in_fire    = in_valid_i && s1_adv;

  // ---------------------------------------------------------------------------
  // Threshold register.
  // ---------------------------------------------------------------------------
  logic [ThrW-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------------
  // History: a row of cells that shifts once per gated beat. The newest sample
  // sits in the first cell, so the taps show the samples leaving each window.
  // ---------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] smp;
  logic                   hist_shift;
  logic [SAMPLE_BITS-1:0] tap_short, tap_long;

  assign smp        = SAMPLE_BITS'(in_data_i.sample);
  assign hist_shift = in_fire && in_data_i.gate_open;

  crgd_chain #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (LONG_WINDOW),
    .TAP   (SHORT_WINDOW)
  ) u_chain (
    .clk_i       (clk_i),
    .shift_i     (hist_shift),
    .data_i      (smp),
    .tap_short_o (tap_short),
    .tap_long_o  (tap_long)
  );

  // ---------------------------------------------------------------------------
  // Running sums and warm-up control, updated on every accepted beat.
  // A cell only feeds a subtraction once the fill count says it was written.
  // ---------------------------------------------------------------------------
  logic [RecentW-1:0] recent_q, recent_d;
  logic [WindowW-1:0] window_q, window_d;
  logic [WindowW-1:0] base_q, base_d;
  logic [WarmW-1:0]   warm_q, warm_d;
  logic [FillW-1:0]   fill_q, fill_d;
  phase_e             phase_d;
  logic [RecentW-1:0] short_leave;
  logic [WindowW-1:0] long_leave;

  always_comb begin
    short_leave = (fill_q >= FillW'(SHORT_WINDOW)) ? RecentW'(tap_short) : '0;
    long_leave  = (fill_q >= FillW'(LONG_WINDOW)) ? WindowW'(tap_long) : '0;
    recent_d    = recent_q;
    window_d    = window_q;
    base_d      = base_q;
    warm_d      = warm_q;
    fill_d      = fill_q;
    phase_d     = PHASE_OFF;
    if (!in_data_i.gate_open) begin
      warm_d = '0;
    end else begin
      recent_d = recent_q - short_leave + RecentW'(smp);
      window_d = window_q - long_leave + WindowW'(smp);
      if (fill_q < FillW'(LONG_WINDOW)) begin
        fill_d = fill_q + FillW'(1);
      end
      priority if (warm_q < WarmW'(WARMUP_TICKS)) begin
        warm_d  = warm_q + WarmW'(1);
        phase_d = PHASE_WARM;
      end else if (warm_q == WarmW'(WARMUP_TICKS)) begin
        // First monitoring beat after warm-up: freeze the baseline.
        warm_d  = warm_q + WarmW'(1);
        base_d  = window_d;
        phase_d = PHASE_MON;
      end else begin
        phase_d = PHASE_MON;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q <= '0;
      window_q <= '0;
      base_q   <= '0;
      warm_q   <= '0;
      fill_q   <= '0;
    end else if (in_fire) begin
      recent_q <= recent_d;
      window_q <= window_d;
      base_q   <= base_d;
      warm_q   <= warm_d;
      fill_q   <= fill_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline valid bits.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_vld_q <= in_fire;
      end
      if (s2_adv) begin
        s2_vld_q <= s1_vld_q;
      end
      if (out_adv) begin
        out_vld_q <= s2_vld_q;
      end
    end
  end

  // Stage 1: snapshot of the sums after this beat.
  phase_e             s1_phase_q;
  logic [RecentW-1:0] s1_recent_q;
  logic [WindowW-1:0] s1_base_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_phase_q  <= phase_d;
      s1_recent_q <= recent_d;
      s1_base_q   <= base_d;
    end
  end

  // Stage 2: the three products by constants, each on its own multiplier.
  phase_e               s2_phase_q;
  logic [ShortSumW-1:0] s2_short_q;
  logic [CmpW-1:0]      s2_lhs_q, s2_base_q, s2_thr_q;
  logic [CmpW-1:0]      lhs_d, base_prod_d, thr_prod_d;

  always_comb begin
    lhs_d       = CmpW'(CmpW'(s1_recent_q) * CmpW'(LhsK));
    base_prod_d = CmpW'(CmpW'(s1_base_q) * CmpW'(BaseK));
    thr_prod_d  = CmpW'(CmpW'(thr_q) * CmpW'(ThrK));
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && s1_vld_q) begin
      s2_phase_q <= s1_phase_q;
      s2_short_q <= ShortSumW'(s1_recent_q);
      s2_lhs_q   <= lhs_d;
      s2_base_q  <= base_prod_d;
      s2_thr_q   <= thr_prod_d;
    end
  end

  // Stage 3: add and compare into the output register.
  out_t            out_d;
  logic [CmpW-1:0] rhs;

  always_comb begin
    rhs             = s2_base_q + s2_thr_q;
    out_d.phase     = s2_phase_q;
    out_d.short_sum = s2_short_q;
    out_d.detected  = (s2_phase_q == PHASE_MON) && (s2_lhs_q > rhs);
  end

  out_t out_q;

  always_ff @(posedge clk_i) begin
    if (out_adv && s2_vld_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_detect_only_monitoring : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.detected |-> out_data_o.phase == PHASE_MON)
    else $error("detection reported outside the monitoring phase");

  a_fill_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(LONG_WINDOW))
    else $error("fill count ran past the history depth");

  a_gate_clears_warmup : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !in_data_i.gate_open |=> warm_q == '0)
    else $error("closed gate did not clear the warm-up count");

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> in_ready_o)
    else $error("input stalled with an empty output stage");

endmodule

// File: rtl/core/crgd_cell.sv
module crgd_cell #(
  parameter int unsigned WIDTH = 12
) (
  input  logic             clk_i,
  input  logic             shift_i,
  input  logic [WIDTH-1:0] data_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] data_q;

  // One history slot: it takes its neighbor's sample on every shift.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;

endmodule

// File: rtl/core/crgd_chain.sv
module crgd_chain #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 100,
  parameter int unsigned TAP   = 10
) (
  input  logic             clk_i,
  input  logic             shift_i,
  input  logic [WIDTH-1:0] data_i,
  output logic [WIDTH-1:0] tap_short_o,
  output logic [WIDTH-1:0] tap_long_o
);

  // link[0] is the incoming sample, link[i + 1] the output of cell i.
  logic [WIDTH-1:0] link [DEPTH+1];

  assign link[0] = data_i;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    crgd_cell #(
      .WIDTH (WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .shift_i (shift_i),
      .data_i  (link[i]),
      .data_o  (link[i+1])
    );
  end

  // Before a shift these are the samples that leave the short and long windows.
  assign tap_short_o = link[TAP];
  assign tap_long_o  = link[DEPTH];

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

// Testbench for the current-rise grip detector.
//
// Every input beat accepted by the block is run through a predictor kept in
// this file, and the expected result is queued. Each result beat leaving the
// block is compared field by field with the oldest queued result. The test
// tasks below are called in turn from one initial block. They all send their
// beats through one task, and one always block does the checking.
module tb;

  import crgd_pkg::*;

  // Block geometry at the default parameter values of the top level.
  localparam int unsigned LongWin   = 100;
  localparam int unsigned ShortWin  = 10;
  localparam int unsigned WarmTicks = 200;
  localparam int unsigned CodeMax   = 4095;

  // Threshold corner values. The documented range ends at ThrTop, and the
  // field itself can reach ThrAllOnes.
  localparam logic [ThrW-1:0] ThrTop     = 19'd409500;
  localparam logic [ThrW-1:0] ThrAllOnes = 19'h7FFFF;

  // Run length and safety limits.
  localparam int unsigned BeatTarget  = 1750;
  localparam int unsigned SettleTicks = 12;
  localparam int unsigned HoldTicks   = 100;
  localparam int unsigned IdlePercent = 23;
  localparam int unsigned CycleLimit  = 400000;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           cfg_we_i;
  logic [ThrW-1:0] cfg_wdata_i;
  logic           in_valid_i;
  logic           in_ready_o;
  in_t            in_data_i;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  out_t           out_data_o;

  current_rise_grip_detector_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state. It mirrors the block after reset: running sums, warm-up
  // count, frozen baseline, circular history and the threshold register.
  logic [SampleW-1:0] hist_mem [LongWin];
  int unsigned        warm_n     = 0;
  int unsigned        recent_acc = 0;
  int unsigned        window_acc = 0;
  int unsigned        base_acc   = 0;
  int unsigned        wr_ptr     = 0;
  int unsigned        filled     = 0;
  logic [ThrW-1:0]    thr_q      = ThrReset;

  out_t        grip_results_due[$];
  int unsigned fault_count = 0;
  int unsigned beats_sent  = 0;
  int unsigned cycle_count = 0;

  // Idling controls. The calm flags switch off random gaps on one side, and
  // hold_left makes the receiver refuse results until it counts down to zero.
  bit          calm_in     = 1'b0;
  bit          calm_out    = 1'b0;
  int unsigned hold_left   = 0;

  initial begin
    foreach (hist_mem[i]) hist_mem[i] = '0;
  end

  // Works out the result of one accepted beat and advances the predictor.
  // A closed gate only clears the warm-up count. An open gate pushes the
  // sample into the history, retires whatever leaves each window once that
  // window is full, and either counts warm-up or compares the short mean
  // with the baseline mean. The baseline is frozen on the first tick after
  // warm-up, and the comparison is done exactly in 64 bits.
  function automatic out_t predict_grip_result(input in_t beat);
    out_t            res;
    longint unsigned lhs;
    longint unsigned rhs;
    res = '0;
    if (!beat.gate_open) begin
      warm_n        = 0;
      res.phase     = PHASE_OFF;
      res.short_sum = recent_acc[ShortSumW-1:0];
      return res;
    end
    if (filled >= ShortWin) begin
      recent_acc -= hist_mem[(wr_ptr + LongWin - ShortWin) % LongWin];
    end
    if (filled >= LongWin) begin
      window_acc -= hist_mem[wr_ptr];
    end
    hist_mem[wr_ptr] = beat.sample;
    recent_acc += beat.sample;
    window_acc += beat.sample;
    wr_ptr = (wr_ptr + 1) % LongWin;
    if (filled < LongWin) filled++;
    if (warm_n < WarmTicks) begin
      warm_n++;
      res.phase = PHASE_WARM;
    end else begin
      if (warm_n == WarmTicks) begin
        warm_n++;
        base_acc = window_acc;
      end
      lhs = 64'd100 * LongWin * longint'(recent_acc);
      rhs = 64'd100 * ShortWin * longint'(base_acc)
          + 64'(ShortWin) * LongWin * longint'(thr_q);
      res.detected = (lhs > rhs);
      res.phase    = PHASE_MON;
    end
    res.short_sum = recent_acc[ShortSumW-1:0];
    return res;
  endfunction

  function automatic void check_field(input string what, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      fault_count++;
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  // Everything is sampled at the rising edge. A threshold write lands in the
  // predictor on the edge that writes it, which is safe because writes only
  // happen while the block is empty. Results are checked before the beat
  // taken on the same edge is predicted; registered stages lie between input
  // and output, so the two can never belong together.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (cfg_we_i) thr_q = cfg_wdata_i;
      if (out_valid_o && out_ready_i) begin
        if (grip_results_due.size() == 0) begin
          fault_count++;
          $display("%0t: result beat %h arrived with nothing expected", $time, out_data_o);
        end else begin
          want = grip_results_due.pop_front();
          check_field("detected", 16'(want.detected), 16'(out_data_o.detected));
          check_field("phase", 16'(want.phase), 16'(out_data_o.phase));
          check_field("short_sum", want.short_sum, out_data_o.short_sum);
        end
      end
      if (in_valid_i && in_ready_o) begin
        grip_results_due.push_back(predict_grip_result(in_data_i));
      end
    end
  end

  // The run is cut off if it ever stalls far beyond its normal length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side. During a hold the receiver refuses everything, otherwise it
  // stalls at random unless it has been told to stay calm.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else begin
      out_ready_i <= calm_out || ($urandom_range(99) >= IdlePercent);
    end
  end

  function automatic logic [SampleW-1:0] to_code(input int v);
    if (v < 0) return '0;
    if (v > int'(CodeMax)) return SampleW'(CodeMax);
    return v[SampleW-1:0];
  endfunction

  // Offers one beat, starting at a falling edge, and returns at the falling
  // edge after it was taken. Valid is left high on return: the caller either
  // offers the next beat at once or lowers valid in this same time step.
  task automatic send_beat(input logic [SampleW-1:0] code, input logic gate);
    while (!calm_in && $urandom_range(99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i          <= 1'b1;
    in_data_i.sample    <= code;
    in_data_i.gate_open <= gate;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    beats_sent++;
    @(negedge clk_i);
  endtask

  // The sender stops and waits for every expected result, then lets the
  // pipeline settle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (grip_results_due.size() != 0) @(negedge clk_i);
    repeat (SettleTicks) @(negedge clk_i);
  endtask

  task automatic write_threshold(input logic [ThrW-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Short hand-picked sequence: closed-gate beats right after reset, full
  // scale and zero samples, the short window filling and starting to retire,
  // a gate drop in the middle of warm-up and alternating bit patterns.
  task automatic test_directed();
    send_beat(12'hFFF, 1'b0);
    send_beat(12'h000, 1'b0);
    repeat (11) send_beat(12'hFFF, 1'b1);
    repeat (2) send_beat(12'h000, 1'b1);
    send_beat(12'hFFF, 1'b0);
    send_beat(12'h000, 1'b1);
    send_beat(12'h800, 1'b1);
    send_beat(12'h555, 1'b1);
    send_beat(12'hAAA, 1'b1);
    send_beat(12'h000, 1'b0);
    send_beat(12'h001, 1'b1);
    send_beat(12'h7FF, 1'b1);
  endtask

  // Warms up on a flat zero level so that the frozen baseline is zero, then
  // walks the threshold through its corners. Ten full-scale samples make the
  // short term exactly 409500, which equals the top of the documented range:
  // that must not detect, while one less must. Equal terms with a zero
  // threshold must not detect either.
  task automatic test_threshold_extremes();
    logic [ThrW-1:0] corner [5];
    corner = '{ThrTop, ThrTop - 19'd1, '0, ThrAllOnes, ThrReset};
    send_beat(12'h000, 1'b0);
    repeat (WarmTicks + 1) send_beat(12'h000, 1'b1);
    foreach (corner[i]) begin
      write_threshold(corner[i]);
      repeat (ShortWin) send_beat(12'hFFF, 1'b1);
      repeat (ShortWin) send_beat(12'h000, 1'b1);
    end
    drain_results();
  endtask

  // The receiver refuses results for a long stretch while the sender keeps
  // offering beats back to back, so the pipeline fills and input stalls.
  // Afterwards the sender pauses until every result has come back.
  task automatic test_backpressure();
    int lvl;
    lvl = $urandom_range(0, CodeMax);
    calm_in = 1'b1;
    @(posedge clk_i);
    hold_left = HoldTicks;
    @(negedge clk_i);
    repeat (150) begin
      send_beat(to_code(lvl + $urandom_range(0, 60) - 30), 1'b1);
    end
    calm_in = 1'b0;
    drain_results();
  endtask

  // Most sessions are well formed: the gate opens, a full warm-up at a
  // steady level freezes the baseline, and the level then steps up and down
  // around the current threshold so detection flips both ways. A few gate
  // drops break sessions in the middle, and some sessions are plain noise
  // with random samples and a random gate. One session runs without any
  // idling on either side.
  task automatic test_random_sessions();
    int          base;
    int          lvl;
    int          jitter;
    int unsigned session;
    session = 0;
    while (beats_sent < BeatTarget) begin
      if ($urandom_range(99) < 50) begin
        case ($urandom_range(5))
          0:       write_threshold('0);
          1:       write_threshold(ThrTop);
          2:       write_threshold(ThrReset);
          default: write_threshold(ThrW'($urandom_range(0, 6000)));
        endcase
      end
      calm_in  = (session == 2);
      calm_out = (session == 2);
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(20, 60)) begin
          send_beat(SampleW'($urandom_range(0, CodeMax)), 1'($urandom_range(1)));
        end
      end else begin
        repeat ($urandom_range(1, 3)) send_beat(SampleW'($urandom), 1'b0);
        base   = $urandom_range(0, CodeMax);
        jitter = $urandom_range(0, 40);
        repeat (WarmTicks) send_beat(to_code(base + $urandom_range(0, 2 * jitter) - jitter), 1'b1);
        repeat ($urandom_range(3, 8)) begin
          case ($urandom_range(3))
            0:       lvl = base - $urandom_range(0, 200);
            1:       lvl = $urandom_range(0, CodeMax);
            default: lvl = base + thr_q / 100 + $urandom_range(0, 8) - 4;
          endcase
          repeat ($urandom_range(5, 25)) begin
            send_beat(to_code(lvl + $urandom_range(0, 2) - 1), 1'b1);
          end
          if ($urandom_range(99) < 10) send_beat(SampleW'($urandom), 1'b0);
        end
      end
      session++;
    end
    calm_in  = 1'b0;
    calm_out = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_threshold_extremes();
    test_backpressure();
    test_random_sessions();

    drain_results();
    repeat (SettleTicks) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: current_rise_grip_detector_top.f
rtl/core/crgd_pkg.sv
rtl/core/crgd_cell.sv
rtl/core/crgd_chain.sv
rtl/core/current_rise_grip_detector_top.sv
test/tb.sv
